@@ sv/rv32x_pkg.sv @@
// shared types, op codes and constants of the rv32 instruction executor
package rv32x_pkg;

    localparam int MEM_BYTES_DEF = 262144;
    localparam int REG_COUNT     = 32;
    localparam int BANKS         = 4;
    localparam int XLEN          = 32;

    // operation codes carried in the input tuser
    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_MUL   = 6'd10;
    localparam logic [5:0] OP_ADDI  = 6'd11;
    localparam logic [5:0] OP_SLTI  = 6'd12;
    localparam logic [5:0] OP_SLTIU = 6'd13;
    localparam logic [5:0] OP_XORI  = 6'd14;
    localparam logic [5:0] OP_ORI   = 6'd15;
    localparam logic [5:0] OP_ANDI  = 6'd16;
    localparam logic [5:0] OP_SLLI  = 6'd17;
    localparam logic [5:0] OP_SRLI  = 6'd18;
    localparam logic [5:0] OP_SRAI  = 6'd19;
    localparam logic [5:0] OP_JALR  = 6'd20;
    localparam logic [5:0] OP_LB    = 6'd21;
    localparam logic [5:0] OP_LH    = 6'd22;
    localparam logic [5:0] OP_LW    = 6'd23;
    localparam logic [5:0] OP_LBU   = 6'd24;
    localparam logic [5:0] OP_LHU   = 6'd25;
    localparam logic [5:0] OP_BEQ   = 6'd26;
    localparam logic [5:0] OP_BNE   = 6'd27;
    localparam logic [5:0] OP_BLT   = 6'd28;
    localparam logic [5:0] OP_BGE   = 6'd29;
    localparam logic [5:0] OP_BLTU  = 6'd30;
    localparam logic [5:0] OP_BGEU  = 6'd31;
    localparam logic [5:0] OP_SB    = 6'd32;
    localparam logic [5:0] OP_SH    = 6'd33;
    localparam logic [5:0] OP_SW    = 6'd34;
    localparam logic [5:0] OP_LUI   = 6'd35;
    localparam logic [5:0] OP_AUIPC = 6'd36;
    localparam logic [5:0] OP_JAL   = 6'd37;

    // access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    typedef enum logic [3:0] {
        K_NOP, K_ALU, K_ALUI, K_JALR, K_LOAD, K_BRANCH, K_STORE, K_LUI, K_AUIPC, K_JAL
    } t_kind;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR,
        ALU_SRL, ALU_SRA, ALU_OR, ALU_AND, ALU_MUL
    } t_alu;

    typedef enum logic [2:0] {
        C_EQ, C_NE, C_LT, C_GE, C_LTU, C_GEU
    } t_cond;

    typedef enum logic [1:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_LOAD
    } t_bstate;

    // classified instruction as it sits in the queue
    typedef struct packed {
        t_kind       kind;
        t_alu        alu;
        t_cond       cond;
        logic [1:0]  size;
        logic        lsigned;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } t_item;

    // result beat
    typedef struct packed {
        logic        halted;
        logic [1:0]  mem_size;
        logic [17:0] mem_address;
        logic        mem_write;
        logic        mem_valid;
        logic [31:0] reg_value;
        logic [4:0]  reg_index;
        logic        reg_write;
        logic [31:0] next_pc;
    } t_result;

    // back end status seen by the top level
    typedef struct packed {
        logic clearing;
        logic pop;
    } t_bstat;

endpackage

@@ sv/rv32x_front.sv @@
// front end: classifies incoming instructions and queues them for the back end
module rv32x_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,  // dest_index, src1_index, src2_index, immediate
    input  logic [5:0]           s_axis_tuser,  // op
    output rv32x_pkg::t_item     o_head,
    output logic                 o_head_vld,
    output logic [1:0]           o_count,
    input  logic                 i_pop
);
    import rv32x_pkg::*;

    t_item      cls;
    logic [5:0] op;
    logic       push;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign op = s_axis_tuser;

    // decode op into kind and sub-operation
    always_comb begin
        cls         = '0;
        cls.kind    = K_NOP;
        cls.alu     = ALU_ADD;
        cls.cond    = C_EQ;
        cls.rd      = s_axis_tdata[4:0];
        cls.rs1     = s_axis_tdata[9:5];
        cls.rs2     = s_axis_tdata[14:10];
        cls.imm     = {{11{s_axis_tdata[35]}}, s_axis_tdata[35:15]};
        cls.size    = SZ_BYTE;
        cls.lsigned = 1'b0;
        if (op inside {[OP_ADD:OP_MUL]}) begin
            cls.kind = K_ALU;
            cls.alu  = t_alu'(op[3:0]);
        end else if (op inside {[OP_ADDI:OP_SRAI]}) begin
            cls.kind = K_ALUI;
            case (op)
                OP_SLTI:  cls.alu = ALU_SLT;
                OP_SLTIU: cls.alu = ALU_SLTU;
                OP_XORI:  cls.alu = ALU_XOR;
                OP_ORI:   cls.alu = ALU_OR;
                OP_ANDI:  cls.alu = ALU_AND;
                OP_SLLI:  cls.alu = ALU_SLL;
                OP_SRLI:  cls.alu = ALU_SRL;
                OP_SRAI:  cls.alu = ALU_SRA;
                default:  cls.alu = ALU_ADD;
            endcase
        end else if (op == OP_JALR) begin
            cls.kind = K_JALR;
        end else if (op inside {[OP_LB:OP_LHU]}) begin
            cls.kind    = K_LOAD;
            cls.lsigned = (op == OP_LB) || (op == OP_LH);
            case (op)
                OP_LH, OP_LHU: cls.size = SZ_HALF;
                OP_LW:         cls.size = SZ_WORD;
                default:       cls.size = SZ_BYTE;
            endcase
        end else if (op inside {[OP_BEQ:OP_BGEU]}) begin
            cls.kind = K_BRANCH;
            case (op)
                OP_BNE:  cls.cond = C_NE;
                OP_BLT:  cls.cond = C_LT;
                OP_BGE:  cls.cond = C_GE;
                OP_BLTU: cls.cond = C_LTU;
                OP_BGEU: cls.cond = C_GEU;
                default: cls.cond = C_EQ;
            endcase
        end else if (op inside {[OP_SB:OP_SW]}) begin
            cls.kind = K_STORE;
            case (op)
                OP_SH:   cls.size = SZ_HALF;
                OP_SW:   cls.size = SZ_WORD;
                default: cls.size = SZ_BYTE;
            endcase
        end else if (op == OP_LUI) begin
            cls.kind = K_LUI;
            cls.imm  = {s_axis_tdata[34:15], 12'd0};
        end else if (op == OP_AUIPC) begin
            cls.kind = K_AUIPC;
            cls.imm  = {s_axis_tdata[34:15], 12'd0};
        end else if (op == OP_JAL) begin
            cls.kind = K_JAL;
        end
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_head        = r_q[r_rp];
    assign o_head_vld    = (r_cnt != 2'd0);
    assign o_count       = r_cnt;

    // queue occupancy
    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_pop);
    end

    // two-entry queue between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

@@ sv/rv32x_back.sv @@
// back end: register file, data memory, execution and result register
module rv32x_back #(
    parameter int MEM_BYTES = rv32x_pkg::MEM_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rv32x_pkg::t_item     i_head,
    input  logic                 i_head_vld,
    output logic                 o_pop,
    output rv32x_pkg::t_result   o_res,
    output logic                 o_res_vld,
    input  logic                 i_res_rdy,
    output rv32x_pkg::t_bstat    o_stat
);
    import rv32x_pkg::*;

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = MEM_BYTES / BANKS;
    localparam int RW   = AW - 2;

    t_bstate r_state, n_state;

    t_item       r_cur;
    logic [31:0] r_a, r_b, r_pc;
    logic [31:0] r_rf [REG_COUNT];
    logic        r_rf_vld [REG_COUNT];
    logic [RW-1:0] r_clr_row;
    t_result     r_res;
    logic        r_res_vld;

    logic        out_free, pop, commit, ld_issue, clearing, is_load;
    logic [31:0] opb, alu_y, sum, pc4, target, val, npc, ld_val;
    logic        take, wr, mv, mw;
    logic [4:0]  sh;
    logic [AW-1:0] maddr;
    logic [1:0]  lo, kmax;
    logic [7:0]  rdata [BANKS];
    logic [7:0]  lb [BANKS];
    logic        st_we;
    t_result     res;

    // register file read with write bypass
    function automatic logic [31:0] rf_read(input logic [4:0] idx, input logic we,
                                            input logic [4:0] wa, input logic [31:0] wd,
                                            input logic [31:0] q, input logic v);
        logic [31:0] r;
        if (idx == 5'd0) begin
            r = '0;
        end else if (we && wa == idx) begin
            r = wd;
        end else if (v) begin
            r = q;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    assign out_free = !r_res_vld || i_res_rdy;
    assign is_load  = (r_cur.kind == K_LOAD);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (&r_clr_row) n_state = S_IDLE;
            S_IDLE:  if (i_head_vld) n_state = S_EXEC;
            S_EXEC: begin
                if (is_load) begin
                    n_state = S_LOAD;
                end else if (out_free) begin
                    n_state = i_head_vld ? S_EXEC : S_IDLE;
                end
            end
            S_LOAD: if (out_free) n_state = i_head_vld ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop      = 1'b0;
        commit   = 1'b0;
        ld_issue = 1'b0;
        clearing = 1'b0;
        case (r_state)
            S_CLEAR: clearing = 1'b1;
            S_IDLE:  pop = i_head_vld;
            S_EXEC: begin
                if (is_load) begin
                    ld_issue = 1'b1;
                end else if (out_free) begin
                    commit = 1'b1;
                    pop    = i_head_vld;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    commit = 1'b1;
                    pop    = i_head_vld;
                end
            end
            default: ;
        endcase
    end

    assign o_pop           = pop;
    assign o_stat.clearing = clearing;
    assign o_stat.pop      = pop;

    // alu
    assign opb = (r_cur.kind == K_ALU) ? r_b : r_cur.imm;
    assign sh  = opb[4:0];
    always_comb begin
        case (r_cur.alu)
            ALU_ADD:  alu_y = r_a + opb;
            ALU_SUB:  alu_y = r_a - opb;
            ALU_SLL:  alu_y = r_a << sh;
            ALU_SLT:  alu_y = {31'd0, $signed(r_a) < $signed(opb)};
            ALU_SLTU: alu_y = {31'd0, r_a < opb};
            ALU_XOR:  alu_y = r_a ^ opb;
            ALU_SRL:  alu_y = r_a >> sh;
            ALU_SRA:  alu_y = 32'($signed(r_a) >>> sh);
            ALU_OR:   alu_y = r_a | opb;
            ALU_AND:  alu_y = r_a & opb;
            ALU_MUL:  alu_y = 32'(r_a * opb);
            default:  alu_y = r_a + opb;
        endcase
    end

    // branch condition
    always_comb begin
        case (r_cur.cond)
            C_EQ:    take = (r_a == r_b);
            C_NE:    take = (r_a != r_b);
            C_LT:    take = $signed(r_a) < $signed(r_b);
            C_GE:    take = !($signed(r_a) < $signed(r_b));
            C_LTU:   take = r_a < r_b;
            C_GEU:   take = r_a >= r_b;
            default: take = 1'b0;
        endcase
    end

    assign sum    = r_a + r_cur.imm;
    assign pc4    = r_pc + 32'd4;
    assign target = r_pc + r_cur.imm;
    assign maddr  = sum[AW-1:0];
    assign lo     = maddr[1:0];
    assign kmax   = {r_cur.size[1], r_cur.size[1] | r_cur.size[0]};

    // load data gathered from the byte banks
    always_comb begin
        for (int k = 0; k < BANKS; k++) begin
            lb[k] = rdata[2'(lo + 2'(k))];
        end
        case (r_cur.size)
            SZ_BYTE: ld_val = {{24{r_cur.lsigned & lb[0][7]}}, lb[0]};
            SZ_HALF: ld_val = {{16{r_cur.lsigned & lb[1][7]}}, lb[1], lb[0]};
            default: ld_val = {lb[3], lb[2], lb[1], lb[0]};
        endcase
    end

    // result of the current instruction
    always_comb begin
        val = '0;
        wr  = 1'b0;
        mv  = 1'b0;
        mw  = 1'b0;
        npc = pc4;
        case (r_cur.kind)
            K_ALU, K_ALUI: begin
                val = alu_y;
                wr  = 1'b1;
            end
            K_JALR: begin
                val = pc4;
                wr  = 1'b1;
                npc = {sum[31:1], 1'b0};
            end
            K_LOAD: begin
                val = ld_val;
                wr  = 1'b1;
                mv  = 1'b1;
            end
            K_BRANCH: if (take) npc = target;
            K_STORE: begin
                mv = 1'b1;
                mw = 1'b1;
            end
            K_LUI: begin
                val = r_cur.imm;
                wr  = 1'b1;
            end
            K_AUIPC: begin
                val = target;
                wr  = 1'b1;
            end
            K_JAL: begin
                val = pc4;
                wr  = 1'b1;
                npc = target;
            end
            default: ;
        endcase
        if (r_cur.rd == 5'd0) begin
            wr = 1'b0;
        end
        res             = '0;
        res.next_pc     = npc;
        res.reg_write   = wr;
        res.reg_index   = wr ? r_cur.rd : 5'd0;
        res.reg_value   = wr ? val : 32'd0;
        res.mem_valid   = mv;
        res.mem_write   = mw;
        res.mem_address = mv ? 18'(maddr) : 18'd0;
        res.mem_size    = mv ? r_cur.size : SZ_BYTE;
        res.halted      = (npc == 32'd0);
    end

    assign st_we = commit && (r_cur.kind == K_STORE);

    // byte banks, one byte lane each
    for (genvar j = 0; j < BANKS; j++) begin : g_bank
        logic [7:0]    r_mem [ROWS];
        logic [7:0]    r_rd;
        logic [1:0]    k;
        logic [AW-1:0] ofs;
        logic [RW-1:0] row;
        logic          we;
        logic [7:0]    wd;

        always_comb begin
            k   = 2'(j) - lo;
            ofs = maddr + AW'(k);
            row = clearing ? r_clr_row : ofs[AW-1:2];
            we  = clearing || (st_we && (k <= kmax));
            wd  = clearing ? 8'd0 : 8'(r_b >> {k, 3'b000});
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[row] <= wd;
            end
            if (ld_issue) begin
                r_rd <= r_mem[row];
            end
        end

        assign rdata[j] = r_rd;
    end

    // control registers and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
            r_pc      <= '0;
            r_res_vld <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_rf_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (commit) begin
                r_pc      <= npc;
                r_res_vld <= 1'b1;
                if (wr) begin
                    r_rf_vld[r_cur.rd] <= 1'b1;
                end
            end else if (i_res_rdy) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // register file write, operand fetch and result register
    always_ff @(posedge i_clk) begin
        if (commit && wr) begin
            r_rf[r_cur.rd] <= val;
        end
        if (commit) begin
            r_res <= res;
        end
        if (pop) begin
            r_cur <= i_head;
            r_a   <= rf_read(i_head.rs1, commit && wr, r_cur.rd, val,
                             r_rf[i_head.rs1], r_rf_vld[i_head.rs1]);
            r_b   <= rf_read(i_head.rs2, commit && wr, r_cur.rd, val,
                             r_rf[i_head.rs2], r_rf_vld[i_head.rs2]);
        end
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

endmodule

@@ sv/rv32_instruction_executor.sv @@
// top level of the rv32 instruction executor: front queue and execution back end
// throughput: one instruction a cycle while the result output is not stalled;
// a load also waits in the load state for its registered data memory read
// a 2-entry queue lets the front keep taking beats while the back end stalls
// reset: synchronous; a clearing pass over all MEM_BYTES/4 rows zeroes the data memory,
// instructions queue but do not run until it ends
module rv32_instruction_executor #(
    parameter int MEM_BYTES = rv32x_pkg::MEM_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // dest_index, src1_index, src2_index, immediate
    input  logic [5:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc, reg_write, reg_index, reg_value, mem_valid, mem_write, mem_address,
    // mem_size, halted
    output logic [95:0]  m_axis_tdata
);
    import rv32x_pkg::*;

    t_item      head;
    logic       head_vld, pop;
    logic [1:0] count;
    t_result    res;
    t_bstat     stat;

    rv32x_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_head        (head),
        .o_head_vld    (head_vld),
        .o_count       (count),
        .i_pop         (pop)
    );

    rv32x_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_head_vld (head_vld),
        .o_pop      (pop),
        .o_res      (res),
        .o_res_vld  (m_axis_tvalid),
        .i_res_rdy  (m_axis_tready),
        .o_stat     (stat)
    );

    // result beat packing
    assign m_axis_tdata = {3'd0, res};

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> count != 2'd0) else $error("pop from empty queue");
    a_no_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !pop) else $error("instruction issued during clearing");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count != 2'd3) else $error("queue overflow");
    a_halt_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[92] == (m_axis_tdata[31:0] == 32'd0)))
        else $error("halt flag disagrees with next pc");
`endif

endmodule

@@ verif/rv32_instruction_executor_tb.sv @@
// self-checking testbench of the rv32 instruction executor, directed and random programs
module rv32_instruction_executor_tb;
    import rv32x_pkg::*;

    localparam int MEMB     = MEM_BYTES_DEF;
    localparam int WD_LIMIT = 200000;
    localparam logic [5:0] OP_NOP_LO = 6'd38, OP_NOP_HI = 6'd63;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // dest_index, src1_index, src2_index, immediate
    logic [5:0]  s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // next_pc .. halted

    // predictor state
    logic [31:0] regs [32];
    logic [31:0] pc_q;
    logic [7:0]  dmem [MEMB];
    t_result     expected_q [$];
    int          mismatches = 0;
    int          watchdog = 0;
    bit          stall_on;

    rv32_instruction_executor uut (.*);

    // clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic logic lt_s(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [31:0] alu_calc(int code, logic [31:0] a, logic [31:0] b);
        case (code)
            0: return a + b;
            1: return a - b;
            2: return a << b[4:0];
            3: return {31'd0, lt_s(a, b)};
            4: return {31'd0, a < b};
            5: return a ^ b;
            6: return a >> b[4:0];
            7: return $unsigned($signed(a) >>> b[4:0]);
            8: return a | b;
            9: return a & b;
            default: return a * b;
        endcase
    endfunction

    // run one instruction against the model state and return its result beat
    function automatic t_result execute_insn(logic [5:0] op, logic [4:0] rd, logic [4:0] rs1,
                                             logic [4:0] rs2, logic [20:0] imm21);
        int imm_map [9] = '{0, 3, 4, 5, 8, 9, 2, 6, 7};
        logic [31:0] a, b, imm, val, npc, ea;
        logic        wr, mv, mw, take;
        logic [1:0]  msz;
        int          nb;
        t_result     r;
        a = (rs1 == 0) ? 32'd0 : regs[rs1];
        b = (rs2 == 0) ? 32'd0 : regs[rs2];
        imm = {{11{imm21[20]}}, imm21};
        npc = pc_q + 32'd4;
        wr = 0; mv = 0; mw = 0; val = 0; msz = 0; ea = 0; take = 0;
        ea = (a + imm) % MEMB;
        if (op <= OP_MUL) begin
            val = alu_calc(op, a, b); wr = 1;
        end else if (op <= OP_SRAI) begin
            val = alu_calc(imm_map[op - OP_ADDI], a, imm); wr = 1;
        end else if (op == OP_JALR) begin
            val = pc_q + 32'd4; wr = 1; npc = (a + imm) & ~32'd1;
        end else if (op <= OP_LHU) begin
            mv = 1; wr = 1;
            msz = (op == OP_LB || op == OP_LBU) ? SZ_BYTE : (op == OP_LW ? SZ_WORD : SZ_HALF);
            nb = 1 << msz;
            for (int k = 0; k < nb; k++) val |= 32'(dmem[(ea + k) % MEMB]) << (8 * k);
            if (op == OP_LB && val[7]) val |= 32'hFFFFFF00;
            if (op == OP_LH && val[15]) val |= 32'hFFFF0000;
        end else if (op <= OP_BGEU) begin
            case (op)
                OP_BEQ:  take = (a == b);
                OP_BNE:  take = (a != b);
                OP_BLT:  take = lt_s(a, b);
                OP_BGE:  take = !lt_s(a, b);
                OP_BLTU: take = (a < b);
                default: take = (a >= b);
            endcase
            if (take) npc = pc_q + imm;
        end else if (op <= OP_SW) begin
            mv = 1; mw = 1; msz = 2'(op - OP_SB);
            nb = 1 << msz;
            for (int k = 0; k < nb; k++) dmem[(ea + k) % MEMB] = b[8*k +: 8];
        end else if (op == OP_LUI) begin
            val = imm << 12; wr = 1;
        end else if (op == OP_AUIPC) begin
            val = pc_q + (imm << 12); wr = 1;
        end else if (op == OP_JAL) begin
            val = pc_q + 32'd4; wr = 1; npc = pc_q + imm;
        end
        if (rd == 0) wr = 0;
        if (wr) regs[rd] = val;
        pc_q = npc;
        r.next_pc     = npc;
        r.reg_write   = wr;
        r.reg_index   = wr ? rd : 5'd0;
        r.reg_value   = wr ? val : 32'd0;
        r.mem_valid   = mv;
        r.mem_write   = mw;
        r.mem_address = mv ? ea[17:0] : 18'd0;
        r.mem_size    = mv ? msz : 2'd0;
        r.halted      = (npc == 0);
        return r;
    endfunction

    // send one instruction beat, with a random gap at burst boundaries
    task automatic send_insn(logic [5:0] op, logic [4:0] rd, logic [4:0] rs1,
                             logic [4:0] rs2, logic [20:0] imm);
        if ($urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'd0, imm, rs2, rs1, rd};
        expected_q.insert(expected_q.size(), execute_insn(op, rd, rs1, rs2, imm));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // receiver stall pattern: alternating free and stalling stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_on <= 1'b0;
        end else begin
            if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
            m_axis_tready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    // compare every result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp pc %h w%0d x%0d=%h m%0d/%0d a%h s%0d h%0d",
                                 exp_r.next_pc, exp_r.reg_write, exp_r.reg_index,
                                 exp_r.reg_value, exp_r.mem_valid, exp_r.mem_write,
                                 exp_r.mem_address, exp_r.mem_size, exp_r.halted,
                                 "\n          got pc %h w%0d x%0d=%h m%0d/%0d a%h s%0d h%0d",
                                 got.next_pc, got.reg_write, got.reg_index, got.reg_value,
                                 got.mem_valid, got.mem_write, got.mem_address,
                                 got.mem_size, got.halted);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WD_LIMIT) begin
            $display("rv32_instruction_executor_tb: done, errors");
            $finish;
        end
    end

    // register loads with extreme and patterned values, then every register op and immediate edge cases on them
    task automatic test_alu_extremes();
        send_insn(OP_LUI, 5'd1, 5'd0, 5'd0, 21'h7FFFF);      // x1 = 7ffff000
        send_insn(OP_ADDI, 5'd1, 5'd1, 5'd0, 21'h0FFF);      // x1 = 7fffffff
        send_insn(OP_LUI, 5'd2, 5'd0, 5'd0, 21'h1FFFFF);     // bit 20 drops out
        send_insn(OP_ADDI, 5'd3, 5'd0, 5'd0, 21'h100000);    // most negative imm
        send_insn(OP_ADDI, 5'd4, 5'd1, 5'd0, 21'd1);         // x4 = 80000000
        for (int o = 0; o <= 10; o++) send_insn(6'(o), 5'd5 + 5'(o), 5'd4, 5'd3, 21'd0);
        send_insn(OP_SRAI, 5'd20, 5'd4, 5'd0, 21'h1FFFFF);   // amount uses low 5 bits
        send_insn(OP_SLTIU, 5'd21, 5'd1, 5'd0, 21'h1FFFFF);
        send_insn(OP_SLTI, 5'd22, 5'd4, 5'd0, 21'd0);
        send_insn(OP_XORI, 5'd0, 5'd1, 5'd0, 21'h0AAAA);     // write to x0 ignored
        send_insn(OP_NOP_HI, 5'd23, 5'd1, 5'd2, 21'h155555);
    endtask

    // memory at the top of the address space, misaligned and wrapping
    task automatic test_memory_wrap();
        send_insn(OP_ADDI, 5'd10, 5'd0, 5'd0, 21'h3FFFF);    // top byte address
        send_insn(OP_SW, 5'd0, 5'd10, 5'd4, 21'd0);
        send_insn(OP_LW, 5'd11, 5'd10, 5'd0, 21'd0);
        send_insn(OP_LH, 5'd12, 5'd10, 5'd0, 21'd0);
        send_insn(OP_LHU, 5'd13, 5'd10, 5'd0, 21'd1);
        send_insn(OP_LB, 5'd14, 5'd0, 5'd0, 21'd2);
        send_insn(OP_LBU, 5'd15, 5'd0, 5'd0, 21'd2);
        send_insn(OP_SB, 5'd0, 5'd3, 5'd3, 21'h100001);
        send_insn(OP_SH, 5'd0, 5'd0, 5'd1, 21'h1FFFFF);      // negative address wraps
    endtask

    // branches, jumps and the halt flag
    task automatic test_control();
        for (int o = OP_BEQ; o <= OP_BGEU; o++) begin
            send_insn(6'(o), 5'd0, 5'd4, 5'd1, 21'd8);
            send_insn(6'(o), 5'd0, 5'd1, 5'd1, 21'h1FFFF0);
        end
        send_insn(OP_JAL, 5'd24, 5'd0, 5'd0, 21'd64);
        send_insn(OP_AUIPC, 5'd25, 5'd0, 5'd0, 21'h80001);
        send_insn(OP_JALR, 5'd26, 5'd26, 5'd0, 21'd3);       // rs1 equals rd, odd target
        send_insn(OP_JALR, 5'd27, 5'd0, 5'd0, 21'd0);        // jump to zero: halt
        send_insn(OP_JAL, 5'd0, 5'd0, 5'd0, 21'hFFFFF);
        send_insn(OP_BEQ, 5'd0, 5'd0, 5'd0, 21'h100000);
    endtask

    // random programs: mostly real ops, immediates often near zero
    task automatic test_random_program(int count);
        logic [5:0]  op;
        logic [20:0] imm;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: op = 6'($urandom_range(0, 19));
                3, 4:    op = 6'($urandom_range(OP_LB, OP_LHU));
                5:       op = 6'($urandom_range(OP_SB, OP_SW));
                6:       op = 6'($urandom_range(OP_BEQ, OP_BGEU));
                7:       op = 6'($urandom_range(OP_LUI, OP_JAL));
                8:       op = ($urandom_range(0, 3) == 0) ?
                              6'($urandom_range(OP_NOP_LO, OP_NOP_HI)) : OP_JALR;
                default: op = 6'($urandom_range(0, 10));
            endcase
            case ($urandom_range(0, 3))
                0:       imm = 21'($urandom_range(0, 63));
                1:       imm = 21'h1FFFFF - 21'($urandom_range(0, 63));
                default: imm = 21'($urandom());
            endcase
            send_insn(op, 5'($urandom()), 5'($urandom_range(0, 7)) * 4 + 5'($urandom_range(0, 3)),
                      5'($urandom()), imm);
        end
    endtask

    initial begin
        pc_q = 0;
        foreach (regs[i]) regs[i] = 0;
        foreach (dmem[i]) dmem[i] = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alu_extremes();
        test_memory_wrap();
        test_control();
        test_random_program(600);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("rv32_instruction_executor_tb: done, clean");
        else
            $display("rv32_instruction_executor_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/rv32x_pkg.sv
sv/rv32x_front.sv
sv/rv32x_back.sv
sv/rv32_instruction_executor.sv
verif/rv32_instruction_executor_tb.sv
